// ===== design/wlse_pkg.sv =====
package wlse_pkg;

    localparam int CORDIC_MAX = 24;
    localparam int CW = 34;
    localparam logic signed [CW-1:0] HALF_PI_30 = 34'sd1686629713;
    localparam logic signed [CW-1:0] PI_30 = 34'sd3373259426;
    localparam logic signed [CW-1:0] GAIN_30 = 34'sd652032874;

    localparam logic REG_RADIUS = 1'b0;
    localparam logic REG_PERIOD = 1'b1;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_WINIT, OP_WSTEP, OP_CINIT, OP_CSTEP, OP_MUL, OP_MSAT,
        OP_SPEED, OP_LEFT, OP_RIGHT, OP_POS, OP_POSFIN, OP_OUT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [4:0] step;
        logic       wsrc;   // 0: leg angle + pitch, 1: mean angle + pitch
    } t_cmd;

    typedef struct packed {
        logic side;
        logic ok;
        logic out_busy;
    } t_stat;

    function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] i);
        case (i)
            5'd0:  atan_q30 = 34'sd843314856;
            5'd1:  atan_q30 = 34'sd497837829;
            5'd2:  atan_q30 = 34'sd263043836;
            5'd3:  atan_q30 = 34'sd133525158;
            5'd4:  atan_q30 = 34'sd67021686;
            5'd5:  atan_q30 = 34'sd33543515;
            5'd6:  atan_q30 = 34'sd16775850;
            5'd7:  atan_q30 = 34'sd8388437;
            5'd8:  atan_q30 = 34'sd4194282;
            5'd9:  atan_q30 = 34'sd2097149;
            5'd10: atan_q30 = 34'sd1048575;
            5'd11: atan_q30 = 34'sd524287;
            5'd12: atan_q30 = 34'sd262143;
            5'd13: atan_q30 = 34'sd131071;
            5'd14: atan_q30 = 34'sd65535;
            5'd15: atan_q30 = 34'sd32767;
            5'd16: atan_q30 = 34'sd16383;
            5'd17: atan_q30 = 34'sd8191;
            5'd18: atan_q30 = 34'sd4095;
            5'd19: atan_q30 = 34'sd2047;
            5'd20: atan_q30 = 34'sd1023;
            5'd21: atan_q30 = 34'sd511;
            5'd22: atan_q30 = 34'sd255;
            5'd23: atan_q30 = 34'sd127;
            default: atan_q30 = '0;
        endcase
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
        if (x > 68'sd2147483647) begin
            sat32 = 32'sh7FFFFFFF;
        end else if (x < -68'sd2147483648) begin
            sat32 = 32'sh80000000;
        end else begin
            sat32 = x[31:0];
        end
    endfunction

endpackage

// ===== design/wlse_ctrl.sv =====
module wlse_ctrl #(
    parameter int WSTEPS = 17,
    parameter int CSTEPS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  wlse_pkg::t_stat i_stat,
    output wlse_pkg::t_cmd  o_cmd
);
    import wlse_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_WINIT  = 13'b0000000000010,
        S_WSTEP  = 13'b0000000000100,
        S_CINIT  = 13'b0000000001000,
        S_CSTEP  = 13'b0000000010000,
        S_MUL    = 13'b0000000100000,
        S_MSAT   = 13'b0000001000000,
        S_SPEED  = 13'b0000010000000,
        S_LEFT   = 13'b0000100000000,
        S_RIGHT  = 13'b0001000000000,
        S_POS    = 13'b0010000000000,
        S_POSFIN = 13'b0100000000000,
        S_OUT    = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic r_phase, n_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_phase <= n_phase;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_phase = r_phase;
        o_cmd.op   = OP_NONE;
        o_cmd.step = r_cnt;
        o_cmd.wsrc = r_phase;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_phase  = 1'b0;
                    n_state  = S_WINIT;
                end
            end
            S_WINIT: begin
                o_cmd.op = OP_WINIT;
                n_cnt    = 5'(WSTEPS - 1);
                n_state  = S_WSTEP;
            end
            S_WSTEP: begin
                o_cmd.op = OP_WSTEP;
                if (r_cnt == 5'd0) begin
                    n_state = r_phase ? S_POS : S_CINIT;
                end else begin
                    n_cnt = r_cnt - 5'd1;
                end
            end
            S_CINIT: begin
                o_cmd.op = OP_CINIT;
                n_cnt    = '0;
                n_state  = S_CSTEP;
            end
            S_CSTEP: begin
                o_cmd.op = OP_CSTEP;
                if (r_cnt == 5'(CSTEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_MUL;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            S_MUL: begin
                o_cmd.op = OP_MUL;
                n_state  = S_MSAT;
            end
            S_MSAT: begin
                o_cmd.op = OP_MSAT;
                if (r_cnt == 5'd3) begin
                    n_state = S_SPEED;
                end else begin
                    n_cnt   = r_cnt + 5'd1;
                    n_state = S_MUL;
                end
            end
            S_SPEED: begin
                o_cmd.op = OP_SPEED;
                n_state  = i_stat.side ? S_RIGHT : S_LEFT;
            end
            S_LEFT: begin
                o_cmd.op = OP_LEFT;
                n_state  = S_IDLE;
            end
            S_RIGHT: begin
                o_cmd.op = OP_RIGHT;
                n_phase  = 1'b1;
                n_state  = i_stat.ok ? S_WINIT : S_OUT;
            end
            S_POS: begin
                o_cmd.op = OP_POS;
                n_state  = S_POSFIN;
            end
            S_POSFIN: begin
                o_cmd.op = OP_POSFIN;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.op = OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/wlse_dp.sv =====
module wlse_dp #(
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wlse_pkg::t_cmd      i_cmd,
    output wlse_pkg::t_stat     o_stat,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    input  logic                i_side,
    input  logic signed [31:0]  i_pitch,
    input  logic signed [31:0]  i_pitch_rate,
    input  logic                i_attitude_ok,
    input  logic signed [31:0]  i_wheel_rate,
    input  logic signed [31:0]  i_link_rate,
    input  logic signed [31:0]  i_leg_length,
    input  logic signed [31:0]  i_leg_angle,
    input  logic signed [31:0]  i_leg_length_rate,
    input  logic signed [31:0]  i_leg_angle_rate,
    input  logic                i_side_ok,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [18:0]  o_theta,
    output logic signed [31:0]  o_theta_rate,
    output logic signed [31:0]  o_position,
    output logic signed [31:0]  o_velocity,
    output logic signed [31:0]  o_pitch_out,
    output logic signed [31:0]  o_pitch_rate_out,
    output logic                o_valid_res
);
    import wlse_pkg::*;

    localparam int WW = 37;
    localparam longint PI48 = 64'sh3243F6A8885A3;
    localparam longint PIQ_L = (PI48 + (64'sd1 <<< (47 - FRAC_BITS))) >>> (48 - FRAC_BITS);
    localparam logic signed [WW-1:0] PI_Q = WW'(PIQ_L);
    localparam logic signed [WW-1:0] TURN = WW'(2 * PIQ_L);
    localparam int ZSH = 30 - FRAC_BITS;

    // config
    logic [30:0] r_radius;
    logic [15:0] r_tp;

    // captured item
    logic r_side, r_good;
    logic signed [31:0] r_pitch, r_prate, r_wrate, r_lrate, r_len, r_ang, r_lenr, r_angr;

    // angle wrap unit
    logic signed [WW-1:0] r_wx;
    logic [WW-1:0] r_wr;
    logic r_wneg, r_wpass;
    logic signed [WW-1:0] w_src, w_res;
    logic [WW-1:0] w_sub;

    // CORDIC
    logic signed [CW-1:0] r_cx, r_cy, r_cz, w_z0, w_xf, w_yf;
    logic r_flip;
    logic signed [31:0] w_sin, w_cos;

    // multiply
    logic signed [32:0] w_ma, w_mb;
    logic signed [65:0] r_prod;
    logic signed [31:0] w_qmul;
    logic signed [31:0] r_t [4];
    logic signed [31:0] r_speed;

    // tick state
    logic r_lp, r_lg, r_ok, r_started;
    logic signed [31:0] r_lspeed, r_lang, r_langr, r_trate, r_vel, r_pos;
    logic signed [18:0] r_theta;
    logic w_ok;
    logic [25:0] w_tp10;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= '0;
            r_tp     <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_RADIUS) begin
                r_radius <= i_cfg_data[30:0];
            end else begin
                r_tp <= i_cfg_data[15:0];
            end
        end
    end

    // wrap source, reduction step and result
    always_comb begin
        if (i_cmd.wsrc) begin
            w_src = WW'(((34'(r_lang) + 34'(r_ang)) >>> 1)) + WW'(r_pitch);
        end else begin
            w_src = WW'(r_ang) + WW'(r_pitch);
        end
        w_sub = WW'(TURN) << i_cmd.step;
        if (r_wpass) begin
            w_res = r_wx;
        end else if (r_wneg) begin
            w_res = (r_wr == '0) ? -PI_Q : -PI_Q - $signed(r_wr) + TURN;
        end else begin
            w_res = (r_wr == '0) ? PI_Q : PI_Q + $signed(r_wr) - TURN;
        end
    end

    assign w_z0 = CW'(w_res) <<< ZSH;
    assign w_xf = r_flip ? -r_cx : r_cx;
    assign w_yf = r_flip ? -r_cy : r_cy;
    assign w_sin = 32'(w_yf >>> ZSH);
    assign w_cos = 32'(w_xf >>> ZSH);

    always_comb begin
        case (i_cmd.step[1:0])
            2'd0: begin
                w_ma = 33'(sat32(68'(r_wrate) + 68'(r_lrate) + 68'(r_prate)));
                w_mb = {2'b00, r_radius};
            end
            2'd1: begin
                w_ma = 33'(r_len);
                w_mb = 33'(sat32(68'(r_angr) + 68'(r_prate)));
            end
            2'd2: begin
                w_ma = 33'(r_t[1]);
                w_mb = 33'(w_cos);
            end
            default: begin
                w_ma = 33'(r_lenr);
                w_mb = 33'(w_sin);
            end
        endcase
        if (i_cmd.op == OP_POS) begin
            w_ma = 33'(r_vel);
            w_mb = {17'd0, r_tp};
        end
    end

    assign w_qmul = sat32(68'(r_prod >>> FRAC_BITS));
    assign w_tp10 = 26'(r_tp) * 26'd10;
    assign w_ok = r_lp && r_lg && r_good && (r_radius != '0) && (r_tp != '0) &&
                  (w_tp10 < (26'd1 << FRAC_BITS));

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_side  <= i_side;
                r_good  <= i_attitude_ok & i_side_ok;
                r_pitch <= i_pitch;
                r_prate <= i_pitch_rate;
                r_wrate <= i_wheel_rate;
                r_lrate <= i_link_rate;
                r_len   <= i_leg_length;
                r_ang   <= i_leg_angle;
                r_lenr  <= i_leg_length_rate;
                r_angr  <= i_leg_angle_rate;
            end
            OP_WINIT: begin
                r_wx <= w_src;
                if (w_src > PI_Q) begin
                    r_wpass <= 1'b0;
                    r_wneg  <= 1'b0;
                    r_wr    <= WW'(w_src - PI_Q);
                end else if (w_src < -PI_Q) begin
                    r_wpass <= 1'b0;
                    r_wneg  <= 1'b1;
                    r_wr    <= WW'(-PI_Q - w_src);
                end else begin
                    r_wpass <= 1'b1;
                    r_wneg  <= 1'b0;
                    r_wr    <= '0;
                end
            end
            OP_WSTEP: begin
                if (r_wr >= w_sub) begin
                    r_wr <= r_wr - w_sub;
                end
            end
            OP_CINIT: begin
                r_cx <= GAIN_30;
                r_cy <= '0;
                if (w_z0 > HALF_PI_30) begin
                    r_cz   <= w_z0 - PI_30;
                    r_flip <= 1'b1;
                end else if (w_z0 < -HALF_PI_30) begin
                    r_cz   <= w_z0 + PI_30;
                    r_flip <= 1'b1;
                end else begin
                    r_cz   <= w_z0;
                    r_flip <= 1'b0;
                end
            end
            OP_CSTEP: begin
                if (r_cz >= 0) begin
                    r_cx <= r_cx - (r_cy >>> i_cmd.step);
                    r_cy <= r_cy + (r_cx >>> i_cmd.step);
                    r_cz <= r_cz - atan_q30(i_cmd.step);
                end else begin
                    r_cx <= r_cx + (r_cy >>> i_cmd.step);
                    r_cy <= r_cy - (r_cx >>> i_cmd.step);
                    r_cz <= r_cz + atan_q30(i_cmd.step);
                end
            end
            OP_MUL: begin
                r_prod <= 66'(w_ma) * 66'(w_mb);
            end
            OP_MSAT: begin
                r_t[i_cmd.step[1:0]] <= w_qmul;
            end
            OP_SPEED: begin
                r_speed <= sat32(68'(r_t[0]) + 68'(r_t[2]) + 68'(r_t[3]));
            end
            OP_RIGHT: begin
                r_ok    <= w_ok;
                r_trate <= sat32(68'((33'(r_langr) + 33'(r_angr)) >>> 1) + 68'(r_prate));
                r_vel   <= 32'((33'(r_lspeed) + 33'(r_speed)) >>> 1);
            end
            OP_POS: begin
                r_prod  <= 66'(w_ma) * 66'(w_mb);
                r_theta <= w_res[18:0];
            end
            default: begin
            end
        endcase
    end

    // left-side hold, position and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lp        <= 1'b0;
            r_lg        <= 1'b0;
            r_lspeed    <= '0;
            r_lang      <= '0;
            r_langr     <= '0;
            r_started   <= 1'b0;
            r_pos       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == OP_OUT) begin
                o_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            case (i_cmd.op)
                OP_LEFT: begin
                    r_lp     <= 1'b1;
                    r_lg     <= r_good;
                    r_lspeed <= r_speed;
                    r_lang   <= r_ang;
                    r_langr  <= r_angr;
                end
                OP_RIGHT: begin
                    r_lp <= 1'b0;
                end
                OP_POSFIN: begin
                    r_started <= 1'b1;
                    if (!r_started) begin
                        r_pos <= '0;
                    end else begin
                        r_pos <= sat32(68'(r_pos) + 68'(w_qmul));
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_OUT) begin
            o_theta          <= r_ok ? r_theta : '0;
            o_theta_rate     <= r_ok ? r_trate : '0;
            o_position       <= r_ok ? r_pos : '0;
            o_velocity       <= r_ok ? r_vel : '0;
            o_pitch_out      <= r_ok ? r_pitch : '0;
            o_pitch_rate_out <= r_ok ? r_prate : '0;
            o_valid_res      <= r_ok;
        end
    end

    assign o_stat.side     = r_side;
    assign o_stat.ok       = w_ok;
    assign o_stat.out_busy = o_out_valid & ~i_out_ready;

endmodule

// ===== design/wheel_leg_state_estimator_core.sv =====
// Wheel-leg state estimator.
// Input channel (i_in_valid / o_in_ready): one request per wheel side, left
// then right, all values signed Q(FRAC_BITS). A left request is held inside;
// a right request produces one result on the output channel
// (o_out_valid / i_out_ready). A right request without a prior left one, a
// bad flag, a zero radius or an out-of-range tick period gives a result with
// o_valid_res low and all fields zero, and leaves position state alone.
// Config channel (i_cfg_valid / o_cfg_ready, always ready): index 0 wheel
// radius, index 1 tick period. Write only while the block is idle.
// Timing: one request at a time. The length of a request is set by the
// one-step-per-cycle angle wrap unit (run twice for a valid right side),
// the CORDIC iterations (TRIG_STEPS of them, capped at 24) and the shared
// 33x33 multiplier.
// The result sits in an output register; a new request is taken while it
// waits, and a following right request stalls only at its final step until
// the receiver takes the previous result.
// Reset clears config to zero, the held left side and the position state.
module wheel_leg_state_estimator_core #(
    parameter int FRAC_BITS  = 16,
    parameter int TRIG_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_side,
    input  logic signed [31:0] i_pitch,
    input  logic signed [31:0] i_pitch_rate,
    input  logic               i_attitude_ok,
    input  logic signed [31:0] i_wheel_rate,
    input  logic signed [31:0] i_link_rate,
    input  logic signed [31:0] i_leg_length,
    input  logic signed [31:0] i_leg_angle,
    input  logic signed [31:0] i_leg_length_rate,
    input  logic signed [31:0] i_leg_angle_rate,
    input  logic               i_side_ok,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [18:0] o_theta,
    output logic signed [31:0] o_theta_rate,
    output logic signed [31:0] o_position,
    output logic signed [31:0] o_velocity,
    output logic signed [31:0] o_pitch_out,
    output logic signed [31:0] o_pitch_rate_out,
    output logic               o_valid_res
);
    import wlse_pkg::*;

    // wrap unit steps: remainder below 2^34, turn at least 2^(FRAC_BITS+2)
    localparam int WSTEPS = 33 - FRAC_BITS;
    localparam int CSTEPS = (TRIG_STEPS < CORDIC_MAX) ? TRIG_STEPS : CORDIC_MAX;

    t_cmd  w_cmd;
    t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    wlse_ctrl #(
        .WSTEPS (WSTEPS),
        .CSTEPS (CSTEPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    wlse_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_side            (i_side),
        .i_pitch           (i_pitch),
        .i_pitch_rate      (i_pitch_rate),
        .i_attitude_ok     (i_attitude_ok),
        .i_wheel_rate      (i_wheel_rate),
        .i_link_rate       (i_link_rate),
        .i_leg_length      (i_leg_length),
        .i_leg_angle       (i_leg_angle),
        .i_leg_length_rate (i_leg_length_rate),
        .i_leg_angle_rate  (i_leg_angle_rate),
        .i_side_ok         (i_side_ok),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_theta           (o_theta),
        .o_theta_rate      (o_theta_rate),
        .o_position        (o_position),
        .o_velocity        (o_velocity),
        .o_pitch_out       (o_pitch_out),
        .o_pitch_rate_out  (o_pitch_rate_out),
        .o_valid_res       (o_valid_res)
    );

endmodule
